FILE: src/ssi_pkg.sv
// Shared types, constants and helpers for the stylus state interpolator.
package ssi_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(15);

   typedef enum logic [1:0] {
      KIND_PEN    = 2'd0,
      KIND_NONPEN = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_EMPTY = 2'd0,
      PHASE_ONE   = 2'd1,
      PHASE_READY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      LANE_PRESSURE = 2'd0,
      LANE_TILT     = 2'd1,
      LANE_ANGLE    = 2'd2
   } lane_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_LOAD_REQ, OP_WRITE_PEN, OP_FIRST, OP_CORD_INIT, OP_CORD_STEP,
      OP_WRITE_SYN, OP_LAT_A, OP_LAT_B, OP_M_DXQX, OP_M_DYQY, OP_M_DXDX,
      OP_M_DYDY, OP_LEN, OP_DIV_STEP, OP_TSEL, OP_M_DXT, OP_M_DYT, OP_M_EXEX,
      OP_M_EYEY, OP_DIST, OP_CMP, OP_LPREP, OP_LM0, OP_LM1, OP_LSUM,
      OP_RES_EMPTY, OP_RES_ONE, OP_PUSH
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_PEN_WR, ST_NP_DEC, ST_CORD_INIT, ST_CORD_STEP, ST_NP_WR,
      ST_Q_DEC, ST_Q1_LAT, ST_Q1_RES, ST_SEG_RDA, ST_SEG_RDB, ST_SEG_LATB,
      ST_M_DXQX, ST_M_DYQY, ST_M_DXDX, ST_M_DYDY, ST_LEN, ST_DIV, ST_TSEL,
      ST_M_DXT, ST_M_DYT, ST_M_EXEX, ST_M_EYEY, ST_DIST, ST_CMP,
      ST_FIN_RDA, ST_FIN_RDB, ST_FIN_LATB, ST_LPREP, ST_LM0, ST_LM1, ST_LSUM,
      ST_PUSH
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic [ADDR_W-1:0]       addr;
      logic [STEP_W-1:0]       step;
      lane_type                lane;
      logic                    first;
   } cmd_type;

   typedef struct packed {
      logic eq_first;
      logic better;
   } stat_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] p;
      logic signed [15:0] tl;
      logic [15:0]        o;
   } point_type;

   function automatic logic [15:0] cordic_step(input logic [STEP_W-1:0] k);
      logic [15:0] v;
      case (k)
         4'd0: v = 16'd8192;
         4'd1: v = 16'd4836;
         4'd2: v = 16'd2555;
         4'd3: v = 16'd1297;
         4'd4: v = 16'd651;
         4'd5: v = 16'd326;
         4'd6: v = 16'd163;
         4'd7: v = 16'd81;
         4'd8: v = 16'd41;
         4'd9: v = 16'd20;
         4'd10: v = 16'd10;
         4'd11: v = 16'd5;
         4'd12: v = 16'd3;
         4'd13: v = 16'd1;
         4'd14: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/ssi_if.sv
// Request and response word channels of the stylus state interpolator.
interface ssi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] x;
   logic signed [31:0] y;
   logic signed [15:0] pen_pressure;
   logic signed [15:0] pen_tilt;
   logic [15:0]        pen_orientation;
   modport source (output valid, kind, x, y, pen_pressure, pen_tilt, pen_orientation,
                   input ready);
   modport sink (input valid, kind, x, y, pen_pressure, pen_tilt, pen_orientation,
                 output ready);
endinterface

interface ssi_rsp_if;
   logic               valid;
   logic               ready;
   logic               known;
   logic signed [15:0] out_pressure;
   logic signed [15:0] out_tilt;
   logic [15:0]        out_orientation;
   modport source (output valid, known, out_pressure, out_tilt, out_orientation,
                   input ready);
   modport sink (input valid, known, out_pressure, out_tilt, out_orientation,
                 output ready);
endinterface

FILE: src/stroke_stylus_state_interpolator_core.sv
// Top level of the stroke stylus state interpolator.
// req_bus takes one word per command: pen add, non-pen add, clear, query.
// rsp_bus returns one word for each query (known flag, pressure, tilt,
// orientation); other commands return nothing.
// Words are handled one at a time; req ready is high only when idle.
// Non-pen add records the first point; the next one, if it differs, runs
// the CORDIC (16 iterations) and writes a synthetic point.
// Query on N points: each segment is walked from the remembered index
// to the end, then the lerps run; each segment uses the shared
// 32x32 multiplier (8 products) and the restoring divider for t.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls with an older result still held, a new
// result waits in the push state until the register frees up.
// Reset clears point count, search index and non-pen phase; the store itself
// is not cleared and needs no clearing pass.
module stroke_stylus_state_interpolator_core (
   input logic    clock,
   input logic    reset,
   ssi_req_if.sink   req_bus,
   ssi_rsp_if.source rsp_bus
);

   ssi_pkg::cmd_type  cmd;
   ssi_pkg::stat_type stat;

   // sequencer: states, point count, remembered segment
   ssi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, arithmetic and the result register
   ssi_dpath u_dpath (
      .clock               (clock),
      .cmd                 (cmd),
      .stat                (stat),
      .req_x               (req_bus.x),
      .req_y               (req_bus.y),
      .req_pen_pressure    (req_bus.pen_pressure),
      .req_pen_tilt        (req_bus.pen_tilt),
      .req_pen_orientation (req_bus.pen_orientation),
      .rsp_known           (rsp_bus.known),
      .rsp_out_pressure    (rsp_bus.out_pressure),
      .rsp_out_tilt        (rsp_bus.out_tilt),
      .rsp_out_orientation (rsp_bus.out_orientation)
   );

   // a word that is not a query never produces a result right behind it
   a_no_rsp_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.kind != ssi_pkg::KIND_QUERY)
      |=> !$rose(rsp_bus.valid))
      else $error("result raised after a non-query word");

   // a result only comes out of the push state, never while idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> !$past(req_bus.ready))
      else $error("result raised while idle");

   // unknown state carries zero payload
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.known) |->
      (rsp_bus.out_pressure == 16'sd0 && rsp_bus.out_tilt == 16'sd0 &&
       rsp_bus.out_orientation == 16'd0))
      else $error("unknown result with nonzero payload");

endmodule

FILE: src/ssi_dpath.sv
// Datapath: point store, shared multiplier, divider, CORDIC and lerp registers.
module ssi_dpath (
   input  logic                 clock,
   input  ssi_pkg::cmd_type     cmd,
   output ssi_pkg::stat_type    stat,
   input  logic signed [31:0]   req_x,
   input  logic signed [31:0]   req_y,
   input  logic signed [15:0]   req_pen_pressure,
   input  logic signed [15:0]   req_pen_tilt,
   input  logic [15:0]          req_pen_orientation,
   output logic                 rsp_known,
   output logic signed [15:0]   rsp_out_pressure,
   output logic signed [15:0]   rsp_out_tilt,
   output logic [15:0]          rsp_out_orientation
);

   function automatic logic signed [30:0] div4(input logic signed [32:0] v);
      logic signed [32:0] b;
      b = v + (v[32] ? 33'sd3 : 33'sd0);
      return b[32:2];
   endfunction

   function automatic logic signed [31:0] tr16(input logic signed [63:0] v);
      logic signed [63:0] b;
      b = v + (v[63] ? 64'sd65535 : 64'sd0);
      return b[47:16];
   endfunction

   ssi_pkg::point_type mem [ssi_pkg::MAX_POINTS];
   ssi_pkg::point_type rd_ff, wdata, seg_a_ff, seg_b_ff;
   logic               mem_we;

   logic signed [31:0] px_ff, py_ff, fx_ff, fy_ff;
   logic signed [15:0] pp_ff, pt_ff;
   logic [15:0]        po_ff;
   logic signed [30:0] dx_ff, dy_ff, qx_ff, qy_ff;
   logic signed [63:0] prod_ff, acc_ff, dot_ff, len2_ff;
   logic [63:0]        rem_ff, dist_ff, best_ff;
   logic [15:0]        quot_ff;
   logic [16:0]        t_ff, best_t_ff;
   logic signed [31:0] ex_ff, ey_ff;
   logic signed [53:0] cx_ff, cy_ff;
   logic [15:0]        z_ff;
   logic signed [17:0] fa_ff, ta_ff;
   logic               res_known_ff;
   logic signed [15:0] res_p_ff, res_t_ff;
   logic [15:0]        res_o_ff;
   logic               rsp_known_ff;
   logic signed [15:0] rsp_p_ff, rsp_t_ff;
   logic [15:0]        rsp_o_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_w, lsum;
   logic signed [32:0] dif_x, dif_y, dif_qx, dif_qy, cd_x, cd_y;
   logic signed [53:0] cx0, cy0, xs, ys;
   logic [63:0]        rem2;
   logic signed [17:0] fa0, ta0, adiff;

   // point store, one write and one registered read port
   always_comb begin
      mem_we = 1'b0;
      wdata = '{x: px_ff, y: py_ff, p: pp_ff, tl: pt_ff, o: po_ff};
      if (cmd.op == ssi_pkg::OP_WRITE_PEN) begin
         mem_we = 1'b1;
      end else if (cmd.op == ssi_pkg::OP_WRITE_SYN) begin
         mem_we = 1'b1;
         wdata.p = -16'sd32768;
         wdata.tl = 16'sd0;
         wdata.o = z_ff - 16'd16384;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[cmd.addr];
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ssi_pkg::OP_M_DXQX: begin mul_a = 32'(dx_ff); mul_b = 32'(qx_ff); end
         ssi_pkg::OP_M_DYQY: begin mul_a = 32'(dy_ff); mul_b = 32'(qy_ff); end
         ssi_pkg::OP_M_DXDX: begin mul_a = 32'(dx_ff); mul_b = 32'(dx_ff); end
         ssi_pkg::OP_M_DYDY: begin mul_a = 32'(dy_ff); mul_b = 32'(dy_ff); end
         ssi_pkg::OP_M_DXT: begin mul_a = 32'(dx_ff); mul_b = signed'({15'd0, t_ff}); end
         ssi_pkg::OP_M_DYT: begin mul_a = 32'(dy_ff); mul_b = signed'({15'd0, t_ff}); end
         ssi_pkg::OP_M_EXEX: begin mul_a = ex_ff; mul_b = ex_ff; end
         ssi_pkg::OP_M_EYEY: begin mul_a = ey_ff; mul_b = ey_ff; end
         ssi_pkg::OP_LM0, ssi_pkg::OP_LM1: begin
            if (cmd.op == ssi_pkg::OP_LM0) begin
               mul_b = signed'({15'd0, 17'(17'd65536 - best_t_ff)});
               case (cmd.lane)
                  ssi_pkg::LANE_PRESSURE: mul_a = 32'(seg_a_ff.p);
                  ssi_pkg::LANE_TILT:     mul_a = 32'(seg_a_ff.tl);
                  default:                mul_a = 32'(fa_ff);
               endcase
            end else begin
               mul_b = signed'({15'd0, best_t_ff});
               case (cmd.lane)
                  ssi_pkg::LANE_PRESSURE: mul_a = 32'(seg_b_ff.p);
                  ssi_pkg::LANE_TILT:     mul_a = 32'(seg_b_ff.tl);
                  default:                mul_a = 32'(ta_ff);
               endcase
            end
         end
         default: ;
      endcase
   end

   assign prod_w = mul_a * mul_b;

   always_comb begin
      dif_x = {rd_ff.x[31], rd_ff.x} - {seg_a_ff.x[31], seg_a_ff.x};
      dif_y = {rd_ff.y[31], rd_ff.y} - {seg_a_ff.y[31], seg_a_ff.y};
      dif_qx = {px_ff[31], px_ff} - {seg_a_ff.x[31], seg_a_ff.x};
      dif_qy = {py_ff[31], py_ff} - {seg_a_ff.y[31], seg_a_ff.y};
      cd_x = {px_ff[31], px_ff} - {fx_ff[31], fx_ff};
      cd_y = {py_ff[31], py_ff} - {fy_ff[31], fy_ff};
      cx0 = {{5{cd_x[32]}}, cd_x, 16'd0};
      cy0 = {{5{cd_y[32]}}, cd_y, 16'd0};
      xs = cx_ff >>> cmd.step;
      ys = cy_ff >>> cmd.step;
      rem2 = {rem_ff[62:0], 1'b0};
      fa0 = signed'({2'b00, seg_a_ff.o});
      ta0 = signed'({2'b00, seg_b_ff.o});
      adiff = ta0 - fa0;
      lsum = acc_ff + prod_ff + 64'sd32768;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_w;
      case (cmd.op)
         ssi_pkg::OP_LOAD_REQ: begin
            px_ff <= req_x;
            py_ff <= req_y;
            pp_ff <= req_pen_pressure;
            pt_ff <= req_pen_tilt;
            po_ff <= req_pen_orientation;
         end
         ssi_pkg::OP_FIRST: begin
            fx_ff <= px_ff;
            fy_ff <= py_ff;
         end
         ssi_pkg::OP_CORD_INIT: begin
            // fold the left half plane by a half turn
            if (cd_x[32]) begin
               cx_ff <= -cx0;
               cy_ff <= -cy0;
               z_ff <= 16'h8000;
            end else begin
               cx_ff <= cx0;
               cy_ff <= cy0;
               z_ff <= 16'h0000;
            end
         end
         ssi_pkg::OP_CORD_STEP: begin
            if (!cy_ff[53]) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               z_ff <= z_ff + ssi_pkg::cordic_step(cmd.step);
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               z_ff <= z_ff - ssi_pkg::cordic_step(cmd.step);
            end
         end
         ssi_pkg::OP_LAT_A: seg_a_ff <= rd_ff;
         ssi_pkg::OP_LAT_B: begin
            seg_b_ff <= rd_ff;
            dx_ff <= div4(dif_x);
            dy_ff <= div4(dif_y);
            qx_ff <= div4(dif_qx);
            qy_ff <= div4(dif_qy);
         end
         ssi_pkg::OP_M_DYQY: acc_ff <= prod_ff;
         ssi_pkg::OP_M_DXDX: dot_ff <= acc_ff + prod_ff;
         ssi_pkg::OP_M_DYDY: acc_ff <= prod_ff;
         ssi_pkg::OP_LEN: begin
            len2_ff <= acc_ff + prod_ff;
            rem_ff <= $unsigned(dot_ff);
            quot_ff <= '0;
         end
         ssi_pkg::OP_DIV_STEP: begin
            if (rem2 >= $unsigned(len2_ff)) begin
               rem_ff <= rem2 - $unsigned(len2_ff);
               quot_ff <= {quot_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem2;
               quot_ff <= {quot_ff[14:0], 1'b0};
            end
         end
         ssi_pkg::OP_TSEL: begin
            if (len2_ff == 64'sd0 || dot_ff <= 64'sd0) begin
               t_ff <= '0;
            end else if (dot_ff >= len2_ff) begin
               t_ff <= 17'd65536;
            end else begin
               t_ff <= {1'b0, quot_ff};
            end
         end
         ssi_pkg::OP_M_DYT: ex_ff <= 32'(qx_ff) - tr16(prod_ff);
         ssi_pkg::OP_M_EXEX: ey_ff <= 32'(qy_ff) - tr16(prod_ff);
         ssi_pkg::OP_M_EYEY: acc_ff <= prod_ff;
         ssi_pkg::OP_DIST: dist_ff <= $unsigned(acc_ff + prod_ff);
         ssi_pkg::OP_CMP: begin
            if (stat.better) begin
               best_ff <= dist_ff;
               best_t_ff <= t_ff;
            end
         end
         ssi_pkg::OP_LPREP: begin
            // shortest way around the circle
            res_known_ff <= 1'b1;
            if (adiff < -18'sd32768) begin
               fa_ff <= fa0;
               ta_ff <= ta0 + 18'sd65536;
            end else if (adiff > 18'sd32768) begin
               fa_ff <= fa0 + 18'sd65536;
               ta_ff <= ta0;
            end else begin
               fa_ff <= fa0;
               ta_ff <= ta0;
            end
         end
         ssi_pkg::OP_LM1: acc_ff <= prod_ff;
         ssi_pkg::OP_LSUM: begin
            case (cmd.lane)
               ssi_pkg::LANE_PRESSURE: res_p_ff <= lsum[31:16];
               ssi_pkg::LANE_TILT:     res_t_ff <= lsum[31:16];
               default:                res_o_ff <= lsum[31:16];
            endcase
         end
         ssi_pkg::OP_RES_EMPTY: begin
            res_known_ff <= 1'b0;
            res_p_ff <= '0;
            res_t_ff <= '0;
            res_o_ff <= '0;
         end
         ssi_pkg::OP_RES_ONE: begin
            res_known_ff <= 1'b1;
            res_p_ff <= seg_a_ff.p;
            res_t_ff <= seg_a_ff.tl;
            res_o_ff <= seg_a_ff.o;
         end
         ssi_pkg::OP_PUSH: begin
            rsp_known_ff <= res_known_ff;
            rsp_p_ff <= res_p_ff;
            rsp_t_ff <= res_t_ff;
            rsp_o_ff <= res_o_ff;
         end
         default: ;
      endcase
   end

   assign stat.eq_first = (px_ff == fx_ff) && (py_ff == fy_ff);
   assign stat.better = cmd.first || (dist_ff <= best_ff);

   assign rsp_known = rsp_known_ff;
   assign rsp_out_pressure = rsp_p_ff;
   assign rsp_out_tilt = rsp_t_ff;
   assign rsp_out_orientation = rsp_o_ff;

endmodule

FILE: src/ssi_ctrl.sv
// Controller: sequences adds, CORDIC, segment walk and lerps; owns count and index.
module ssi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ssi_pkg::stat_type    stat,
   output ssi_pkg::cmd_type     cmd
);

   ssi_pkg::state_type state_ff, state_in;
   logic [ssi_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ssi_pkg::ADDR_W-1:0] ss_ff, ss_in, seg_ff, seg_in, last;
   ssi_pkg::phase_type         phase_ff, phase_in;
   logic [ssi_pkg::STEP_W-1:0] step_ff, step_in;
   ssi_pkg::lane_type          lane_ff, lane_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accept, room, out_free;

   assign accept = req_valid && (state_ff == ssi_pkg::ST_IDLE);
   assign room = count_ff < ssi_pkg::CNT_W'(ssi_pkg::MAX_POINTS);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last = ssi_pkg::ADDR_W'(count_ff - ssi_pkg::CNT_W'(2));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssi_pkg::ST_IDLE: begin
            if (accept) begin
               case (ssi_pkg::kind_type'(req_kind))
                  ssi_pkg::KIND_PEN:    state_in = ssi_pkg::ST_PEN_WR;
                  ssi_pkg::KIND_NONPEN: state_in = ssi_pkg::ST_NP_DEC;
                  ssi_pkg::KIND_QUERY:  state_in = ssi_pkg::ST_Q_DEC;
                  default:              state_in = ssi_pkg::ST_IDLE;
               endcase
            end
         end
         ssi_pkg::ST_PEN_WR: state_in = ssi_pkg::ST_IDLE;
         ssi_pkg::ST_NP_DEC: begin
            if (phase_ff == ssi_pkg::PHASE_ONE && !stat.eq_first) begin
               state_in = ssi_pkg::ST_CORD_INIT;
            end else begin
               state_in = ssi_pkg::ST_IDLE;
            end
         end
         ssi_pkg::ST_CORD_INIT: state_in = ssi_pkg::ST_CORD_STEP;
         ssi_pkg::ST_CORD_STEP: begin
            if (step_ff == ssi_pkg::STEP_LAST) state_in = ssi_pkg::ST_NP_WR;
         end
         ssi_pkg::ST_NP_WR: state_in = ssi_pkg::ST_IDLE;
         ssi_pkg::ST_Q_DEC: begin
            if (count_ff == '0) begin
               state_in = ssi_pkg::ST_PUSH;
            end else if (count_ff == ssi_pkg::CNT_W'(1)) begin
               state_in = ssi_pkg::ST_Q1_LAT;
            end else begin
               state_in = ssi_pkg::ST_SEG_RDA;
            end
         end
         ssi_pkg::ST_Q1_LAT:   state_in = ssi_pkg::ST_Q1_RES;
         ssi_pkg::ST_Q1_RES:   state_in = ssi_pkg::ST_PUSH;
         ssi_pkg::ST_SEG_RDA:  state_in = ssi_pkg::ST_SEG_RDB;
         ssi_pkg::ST_SEG_RDB:  state_in = ssi_pkg::ST_SEG_LATB;
         ssi_pkg::ST_SEG_LATB: state_in = ssi_pkg::ST_M_DXQX;
         ssi_pkg::ST_M_DXQX:   state_in = ssi_pkg::ST_M_DYQY;
         ssi_pkg::ST_M_DYQY:   state_in = ssi_pkg::ST_M_DXDX;
         ssi_pkg::ST_M_DXDX:   state_in = ssi_pkg::ST_M_DYDY;
         ssi_pkg::ST_M_DYDY:   state_in = ssi_pkg::ST_LEN;
         ssi_pkg::ST_LEN:      state_in = ssi_pkg::ST_DIV;
         ssi_pkg::ST_DIV: begin
            if (step_ff == ssi_pkg::STEP_LAST) state_in = ssi_pkg::ST_TSEL;
         end
         ssi_pkg::ST_TSEL:     state_in = ssi_pkg::ST_M_DXT;
         ssi_pkg::ST_M_DXT:    state_in = ssi_pkg::ST_M_DYT;
         ssi_pkg::ST_M_DYT:    state_in = ssi_pkg::ST_M_EXEX;
         ssi_pkg::ST_M_EXEX:   state_in = ssi_pkg::ST_M_EYEY;
         ssi_pkg::ST_M_EYEY:   state_in = ssi_pkg::ST_DIST;
         ssi_pkg::ST_DIST:     state_in = ssi_pkg::ST_CMP;
         ssi_pkg::ST_CMP: begin
            state_in = (seg_ff == last) ? ssi_pkg::ST_FIN_RDA : ssi_pkg::ST_SEG_RDA;
         end
         ssi_pkg::ST_FIN_RDA:  state_in = ssi_pkg::ST_FIN_RDB;
         ssi_pkg::ST_FIN_RDB:  state_in = ssi_pkg::ST_FIN_LATB;
         ssi_pkg::ST_FIN_LATB: state_in = ssi_pkg::ST_LPREP;
         ssi_pkg::ST_LPREP:    state_in = ssi_pkg::ST_LM0;
         ssi_pkg::ST_LM0:      state_in = ssi_pkg::ST_LM1;
         ssi_pkg::ST_LM1:      state_in = ssi_pkg::ST_LSUM;
         ssi_pkg::ST_LSUM: begin
            state_in = (lane_ff == ssi_pkg::LANE_ANGLE) ? ssi_pkg::ST_PUSH : ssi_pkg::ST_LM0;
         end
         ssi_pkg::ST_PUSH: begin
            if (out_free) state_in = ssi_pkg::ST_IDLE;
         end
         default: state_in = ssi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = ssi_pkg::OP_IDLE;
      cmd.addr = seg_ff;
      cmd.step = step_ff;
      cmd.lane = lane_ff;
      cmd.first = (seg_ff == ss_ff);
      req_ready = 1'b0;
      unique case (state_ff)
         ssi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) cmd.op = ssi_pkg::OP_LOAD_REQ;
         end
         ssi_pkg::ST_PEN_WR: begin
            cmd.addr = count_ff[ssi_pkg::ADDR_W-1:0];
            if (room) cmd.op = ssi_pkg::OP_WRITE_PEN;
         end
         ssi_pkg::ST_NP_DEC: begin
            if (phase_ff == ssi_pkg::PHASE_EMPTY) cmd.op = ssi_pkg::OP_FIRST;
         end
         ssi_pkg::ST_CORD_INIT: cmd.op = ssi_pkg::OP_CORD_INIT;
         ssi_pkg::ST_CORD_STEP: cmd.op = ssi_pkg::OP_CORD_STEP;
         ssi_pkg::ST_NP_WR: begin
            cmd.addr = count_ff[ssi_pkg::ADDR_W-1:0];
            if (room) cmd.op = ssi_pkg::OP_WRITE_SYN;
         end
         ssi_pkg::ST_Q_DEC: begin
            cmd.addr = '0;
            if (count_ff == '0) cmd.op = ssi_pkg::OP_RES_EMPTY;
         end
         ssi_pkg::ST_Q1_LAT: cmd.op = ssi_pkg::OP_LAT_A;
         ssi_pkg::ST_Q1_RES: cmd.op = ssi_pkg::OP_RES_ONE;
         ssi_pkg::ST_SEG_RDA: cmd.addr = seg_ff;
         ssi_pkg::ST_SEG_RDB: begin
            cmd.addr = seg_ff + ssi_pkg::ADDR_W'(1);
            cmd.op = ssi_pkg::OP_LAT_A;
         end
         ssi_pkg::ST_SEG_LATB: cmd.op = ssi_pkg::OP_LAT_B;
         ssi_pkg::ST_M_DXQX:   cmd.op = ssi_pkg::OP_M_DXQX;
         ssi_pkg::ST_M_DYQY:   cmd.op = ssi_pkg::OP_M_DYQY;
         ssi_pkg::ST_M_DXDX:   cmd.op = ssi_pkg::OP_M_DXDX;
         ssi_pkg::ST_M_DYDY:   cmd.op = ssi_pkg::OP_M_DYDY;
         ssi_pkg::ST_LEN:      cmd.op = ssi_pkg::OP_LEN;
         ssi_pkg::ST_DIV:      cmd.op = ssi_pkg::OP_DIV_STEP;
         ssi_pkg::ST_TSEL:     cmd.op = ssi_pkg::OP_TSEL;
         ssi_pkg::ST_M_DXT:    cmd.op = ssi_pkg::OP_M_DXT;
         ssi_pkg::ST_M_DYT:    cmd.op = ssi_pkg::OP_M_DYT;
         ssi_pkg::ST_M_EXEX:   cmd.op = ssi_pkg::OP_M_EXEX;
         ssi_pkg::ST_M_EYEY:   cmd.op = ssi_pkg::OP_M_EYEY;
         ssi_pkg::ST_DIST:     cmd.op = ssi_pkg::OP_DIST;
         ssi_pkg::ST_CMP:      cmd.op = ssi_pkg::OP_CMP;
         ssi_pkg::ST_FIN_RDA:  cmd.addr = ss_ff;
         ssi_pkg::ST_FIN_RDB: begin
            cmd.addr = ss_ff + ssi_pkg::ADDR_W'(1);
            cmd.op = ssi_pkg::OP_LAT_A;
         end
         ssi_pkg::ST_FIN_LATB: cmd.op = ssi_pkg::OP_LAT_B;
         ssi_pkg::ST_LPREP:    cmd.op = ssi_pkg::OP_LPREP;
         ssi_pkg::ST_LM0:      cmd.op = ssi_pkg::OP_LM0;
         ssi_pkg::ST_LM1:      cmd.op = ssi_pkg::OP_LM1;
         ssi_pkg::ST_LSUM:     cmd.op = ssi_pkg::OP_LSUM;
         ssi_pkg::ST_PUSH: begin
            if (out_free) cmd.op = ssi_pkg::OP_PUSH;
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      ss_in = ss_ff;
      seg_in = seg_ff;
      phase_in = phase_ff;
      step_in = step_ff;
      lane_in = lane_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ssi_pkg::ST_IDLE: begin
            if (accept && ssi_pkg::kind_type'(req_kind) == ssi_pkg::KIND_CLEAR) begin
               count_in = '0;
               ss_in = '0;
               phase_in = ssi_pkg::PHASE_EMPTY;
            end
         end
         ssi_pkg::ST_PEN_WR: begin
            if (room) count_in = count_ff + ssi_pkg::CNT_W'(1);
         end
         ssi_pkg::ST_NP_DEC: begin
            if (phase_ff == ssi_pkg::PHASE_EMPTY) phase_in = ssi_pkg::PHASE_ONE;
         end
         ssi_pkg::ST_CORD_INIT, ssi_pkg::ST_LEN: step_in = '0;
         ssi_pkg::ST_CORD_STEP, ssi_pkg::ST_DIV: step_in = step_ff + ssi_pkg::STEP_W'(1);
         ssi_pkg::ST_NP_WR: begin
            if (room) count_in = count_ff + ssi_pkg::CNT_W'(1);
            phase_in = ssi_pkg::PHASE_READY;
         end
         ssi_pkg::ST_Q_DEC: begin
            // pull the remembered segment back inside the polyline
            if (ss_ff > last) begin
               ss_in = last;
               seg_in = last;
            end else begin
               seg_in = ss_ff;
            end
         end
         ssi_pkg::ST_CMP: begin
            if (stat.better) ss_in = seg_ff;
            if (seg_ff != last) seg_in = seg_ff + ssi_pkg::ADDR_W'(1);
         end
         ssi_pkg::ST_LPREP: lane_in = ssi_pkg::LANE_PRESSURE;
         ssi_pkg::ST_LSUM: begin
            if (lane_ff != ssi_pkg::LANE_ANGLE) lane_in = ssi_pkg::lane_type'(lane_ff + 2'd1);
         end
         ssi_pkg::ST_PUSH: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssi_pkg::ST_IDLE;
         count_ff <= '0;
         ss_ff <= '0;
         seg_ff <= '0;
         phase_ff <= ssi_pkg::PHASE_EMPTY;
         step_ff <= '0;
         lane_ff <= ssi_pkg::LANE_PRESSURE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ss_ff <= ss_in;
         seg_ff <= seg_in;
         phase_ff <= phase_in;
         step_ff <= step_in;
         lane_ff <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
